// ===== hdl/cpc_pkg.sv =====
// cpc_pkg: types, codes and constants shared by the cursor pixel converter
// used by every module of the converter and by its stream interfaces
`default_nettype none

package cpc_pkg;

  localparam int unsigned SLOT_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FMT_W  = 2;

  localparam logic [DATA_W-1:0] RGB_MASK   = 32'h00ff_ffff;
  localparam logic [DATA_W-1:0] ALPHA_FULL = 32'hff00_0000;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB32  = 2'd0,
    FMT_RGB555 = 2'd1,
    FMT_PAL4   = 2'd2
  } fmt_e;

  typedef enum logic {
    CMD_CONVERT   = 1'b0,
    CMD_PAL_WRITE = 1'b1
  } cmd_e;

  // item held in the input stage
  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] source_value;
    logic              odd_column;
    logic              and_bit;
    logic [SLOT_W-1:0] palette_slot;
  } cpc_item_t;

  // decoded pixel handed from the decode stage to the mask stage
  typedef struct packed {
    logic [DATA_W-1:0] pix;
    logic              use_pal;
    logic              pal_ok;
    logic              and_bit;
  } cpc_dec_t;

  // 5:5:5 channels each moved into the top of its byte
  function automatic logic [DATA_W-1:0] expand_555(input logic [DATA_W-1:0] v);
    expand_555 = {8'h00, v[14:10], 3'b000, v[9:5], 3'b000, v[4:0], 3'b000};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cpc_in_if.sv =====
// cpc_in_if: valid/ready stream carrying one converter input item
// depends on cpc_pkg for field widths
`default_nettype none

interface cpc_in_if
  import cpc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              command;
  logic [DATA_W-1:0] source_value;
  logic              odd_column;
  logic              and_bit;
  logic [SLOT_W-1:0] palette_slot;

  modport source (
    output valid, command, source_value, odd_column, and_bit, palette_slot,
    input  ready
  );

  modport sink (
    input  valid, command, source_value, odd_column, and_bit, palette_slot,
    output ready
  );

endinterface

`default_nettype wire

// ===== hdl/cpc_out_if.sv =====
// cpc_out_if: valid/ready stream carrying one converted ARGB pixel
// depends on cpc_pkg for field widths
`default_nettype none

interface cpc_out_if
  import cpc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] argb;
  logic              invert;

  modport source (
    output valid, argb, invert,
    input  ready
  );

  modport sink (
    input  valid, argb, invert,
    output ready
  );

endinterface

`default_nettype wire

// ===== hdl/cursor_pixel_converter.sv =====
// cursor_pixel_converter: an input transfer is registered in the input, decode and mask stages before result valid
// throughput one item per cycle unless the output stalls; input, decode/palette read, mask/output stages
// palette writes take one transfer each and yield no result
// reset clears stage valid bits and sets the format to 32-bit color
// palette contents are undefined after reset until written
`default_nettype none

module cursor_pixel_converter
  import cpc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [FMT_W-1:0] cfg_wdata_i,
  cpc_in_if.sink                pix_in,
  cpc_out_if.source             pix_out
);

  fmt_e              fmt_q;
  logic              s1_valid_q;
  cpc_item_t         s1_q;
  logic              s2_valid;
  cpc_dec_t          s2_dec;
  logic [DATA_W-1:0] s2_pal;
  logic              s3_valid;
  logic              en1;
  logic              en2;
  logic              en3;

  // a stage moves when it is empty or the stage after it moves
  assign en3 = !s3_valid || pix_out.ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid_q || en2;
  assign pix_in.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RGB32;
    end else if (cfg_we_i) begin
      fmt_q <= fmt_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= pix_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && pix_in.valid) begin
      s1_q.command      <= pix_in.command;
      s1_q.source_value <= pix_in.source_value;
      s1_q.odd_column   <= pix_in.odd_column;
      s1_q.and_bit      <= pix_in.and_bit;
      s1_q.palette_slot <= pix_in.palette_slot;
    end
  end

  cpc_decode #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en2),
    .valid_i    (s1_valid_q),
    .item_i     (s1_q),
    .fmt_i      (fmt_q),
    .valid_o    (s2_valid),
    .dec_o      (s2_dec),
    .pal_data_o (s2_pal)
  );

  cpc_mask u_mask (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en3),
    .valid_i    (s2_valid),
    .dec_i      (s2_dec),
    .pal_data_i (s2_pal),
    .valid_o    (s3_valid),
    .argb_o     (pix_out.argb),
    .invert_o   (pix_out.invert)
  );

  assign pix_out.valid = s3_valid;

  a_pal_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && en2 && (s1_q.command == CMD_PAL_WRITE)) |=> !s2_valid)
    else $error("palette write produced a result");

  a_convert_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && en2 && (s1_q.command == CMD_CONVERT)) |=> s2_valid)
    else $error("convert item lost between input and decode stage");

  a_invert_transparent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_out.valid && pix_out.invert) |-> (pix_out.argb == '0))
    else $error("inverted pixel is not transparent");

  a_opaque_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_out.valid && (pix_out.argb != '0)) |-> (pix_out.argb[31:24] == 8'hff))
    else $error("visible pixel without full alpha");

endmodule

`default_nettype wire

// ===== hdl/cpc_decode.sv =====
// cpc_decode: second pipeline stage, format decode and palette memory
// depends on cpc_pkg; palette has one write port and one registered read
`default_nettype none

module cpc_decode
  import cpc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire cpc_item_t         item_i,
  input  wire fmt_e              fmt_i,
  output logic                   valid_o,
  output cpc_dec_t               dec_o,
  output logic [DATA_W-1:0]      pal_data_o
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  logic [DATA_W-1:0] mem [PALETTE_ENTRIES];
  logic [DATA_W-1:0] rd_q;
  logic              valid_q;
  cpc_dec_t          dec_q;
  cpc_dec_t          dec_d;
  logic [SLOT_W-1:0] nibble;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic              slot_ok;
  logic              wr_en;

  assign nibble  = item_i.odd_column ? item_i.source_value[3:0]
                                     : item_i.source_value[7:4];
  assign raddr   = AW'(nibble);
  assign waddr   = AW'(item_i.palette_slot);
  assign slot_ok = 32'(item_i.palette_slot) < 32'(PALETTE_ENTRIES);
  assign wr_en   = en_i && valid_i && (item_i.command == CMD_PAL_WRITE) && slot_ok;

  always_comb begin
    dec_d.and_bit = item_i.and_bit;
    dec_d.use_pal = 1'b0;
    dec_d.pal_ok  = 32'(nibble) < 32'(PALETTE_ENTRIES);
    case (fmt_i)
      FMT_RGB555: begin
        dec_d.pix = expand_555(item_i.source_value);
      end
      FMT_PAL4: begin
        dec_d.pix     = item_i.source_value;
        dec_d.use_pal = 1'b1;
      end
      default: begin
        dec_d.pix = item_i.source_value;
      end
    endcase
  end

  // writes and reads come from items in order, so no bypass is needed
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= item_i.source_value;
    end
    if (en_i) begin
      rd_q  <= mem[raddr];
      dec_q <= dec_d;
    end
  end

  // palette writes end here and never make a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i && (item_i.command == CMD_CONVERT);
    end
  end

  assign valid_o    = valid_q;
  assign dec_o      = dec_q;
  assign pal_data_o = rd_q;

endmodule

`default_nettype wire

// ===== hdl/cpc_mask.sv =====
// cpc_mask: third pipeline stage, AND-mask handling and output register
// depends on cpc_pkg
`default_nettype none

module cpc_mask
  import cpc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire cpc_dec_t          dec_i,
  input  wire logic [DATA_W-1:0] pal_data_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      argb_o,
  output logic                   invert_o
);

  logic              valid_q;
  logic [DATA_W-1:0] argb_q;
  logic [DATA_W-1:0] argb_d;
  logic              invert_q;
  logic              invert_d;
  logic [DATA_W-1:0] pix;
  logic [DATA_W-1:0] rgb;

  always_comb begin
    if (dec_i.use_pal) begin
      pix = dec_i.pal_ok ? pal_data_i : '0;
    end else begin
      pix = dec_i.pix;
    end
    rgb      = pix & RGB_MASK;
    invert_d = 1'b0;
    if (dec_i.and_bit && (rgb == '0)) begin
      argb_d = '0;
    end else if (dec_i.and_bit && (rgb == RGB_MASK)) begin
      argb_d   = '0;
      invert_d = 1'b1;
    end else begin
      argb_d = pix | ALPHA_FULL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      argb_q   <= argb_d;
      invert_q <= invert_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o  = valid_q;
  assign argb_o   = argb_q;
  assign invert_o = invert_q;

endmodule

`default_nettype wire

// ===== tb/sv/cursor_pixel_converter_tb.sv =====
`timescale 1ns / 100ps
// cursor_pixel_converter_tb: self-checking bench for the cursor pixel converter
// sends pixel and palette transfers, predicts each ARGB result and checks it in order
// depends on cpc_pkg, cpc_in_if, cpc_out_if and cursor_pixel_converter

module cursor_pixel_converter_tb;
  import cpc_pkg::*;

  localparam int unsigned PAL_ENTRIES  = 16;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 128;

  typedef struct packed {
    logic [DATA_W-1:0] argb;
    logic              invert;
  } argb_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [FMT_W-1:0] cfg_wdata_i;

  cpc_in_if  pix_in ();
  cpc_out_if pix_out ();

  cursor_pixel_converter #(
    .PALETTE_ENTRIES(PAL_ENTRIES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_in      (pix_in),
    .pix_out     (pix_out)
  );

  cpc_item_t              pending_pixels[$];
  argb_result_t           predicted_argb[$];
  fmt_e                   cur_format;
  logic [DATA_W-1:0]      pal_shadow[PAL_ENTRIES];
  // entries the generated sequence has loaded so far
  logic [PAL_ENTRIES-1:0] pal_loaded;
  int unsigned            fail_count  = 0;
  int unsigned            gap_in      = 0;
  int unsigned            calm_in     = 0;
  int unsigned            stall_out   = 0;
  int unsigned            calm_out    = 0;
  int unsigned            idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  // mostly short gaps, a few long ones, now and then a stretch with none
  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // black and white are the interesting colors for the mask logic
  function automatic logic [23:0] pick_rgb();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 24'h00_0000;
    if (r < 50) return 24'hff_ffff;
    return 24'($urandom());
  endfunction

  function automatic argb_result_t convert_pixel(input cpc_item_t it);
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] pix;
    logic [3:0]        idx;
    argb_result_t      res;
    v = it.source_value;
    case (cur_format)
      FMT_RGB555: begin
        pix = ((v & 32'h1f) << 3) | ((v & 32'h3e0) << 6) | ((v & 32'h7c00) << 9);
      end
      FMT_PAL4: begin
        idx = it.odd_column ? v[3:0] : v[7:4];
        pix = (idx < PAL_ENTRIES) ? pal_shadow[idx] : '0;
      end
      default: begin
        pix = v;
      end
    endcase
    res.invert = 1'b0;
    if (it.and_bit && (pix & RGB_MASK) == '0) begin
      res.argb = '0;
    end else if (it.and_bit && (pix & RGB_MASK) == RGB_MASK) begin
      res.argb   = '0;
      res.invert = 1'b1;
    end else begin
      res.argb = pix | ALPHA_FULL;
    end
    return res;
  endfunction

  task automatic push_convert(input logic [DATA_W-1:0] v, input logic odd, input logic mask);
    cpc_item_t it;
    it.command      = CMD_CONVERT;
    it.source_value = v;
    it.odd_column   = odd;
    it.and_bit      = mask;
    it.palette_slot = 4'($urandom_range(0, 15));
    pending_pixels.push_back(it);
  endtask

  task automatic push_pal_write(input logic [SLOT_W-1:0] slot, input logic [DATA_W-1:0] word);
    cpc_item_t it;
    it.command      = CMD_PAL_WRITE;
    it.source_value = word;
    it.odd_column   = 1'($urandom_range(0, 1));
    it.and_bit      = 1'($urandom_range(0, 1));
    it.palette_slot = slot;
    pending_pixels.push_back(it);
    pal_loaded[slot] = 1'b1;
  endtask

  task automatic push_random_convert(input fmt_e fmt);
    logic [DATA_W-1:0] v;
    logic              odd;
    logic [3:0]        idx;
    v   = $urandom();
    odd = 1'($urandom_range(0, 1));
    case (fmt)
      FMT_RGB32: begin
        v[23:0] = pick_rgb();
      end
      FMT_RGB555: begin
        case ($urandom_range(0, 3))
          0: v[14:0] = '0;
          1: v[14:0] = '1;
          default: ;
        endcase
      end
      default: begin
        // the selected nibble must point at a loaded entry
        idx = 4'($urandom_range(0, PAL_ENTRIES - 1));
        while (!pal_loaded[idx]) idx = 4'($urandom_range(0, PAL_ENTRIES - 1));
        if (odd) begin
          v[3:0] = idx;
        end else begin
          v[7:4] = idx;
        end
      end
    endcase
    push_convert(v, odd, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || pix_in.valid || predicted_argb.size() != 0)
      @(posedge clk_i);
    // palette writes give no result, so let the pipeline empty
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_format(input fmt_e fmt);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fmt;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_format = fmt;
  endtask

  // input driver
  always @(posedge clk_i) begin : driver
    cpc_item_t nxt;
    if (!rst_ni) begin
      pix_in.valid <= 1'b0;
    end else if (!pix_in.valid || pix_in.ready) begin
      if (gap_in > 0) begin
        gap_in--;
        pix_in.valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        nxt = pending_pixels.pop_front();
        pix_in.command      <= nxt.command;
        pix_in.source_value <= nxt.source_value;
        pix_in.odd_column   <= nxt.odd_column;
        pix_in.and_bit      <= nxt.and_bit;
        pix_in.palette_slot <= nxt.palette_slot;
        pix_in.valid        <= 1'b1;
        gap_in = next_gap(calm_in);
      end else begin
        pix_in.valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
    end else if (stall_out > 0) begin
      stall_out--;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= 1'b1;
      stall_out = next_gap(calm_out);
    end
  end

  // monitor, predictor update, result check and watchdog
  always @(posedge clk_i) begin : monitor
    cpc_item_t    seen;
    argb_result_t want;
    logic         in_xfer;
    logic         out_xfer;
    if (rst_ni) begin
      in_xfer  = pix_in.valid && pix_in.ready;
      out_xfer = pix_out.valid && pix_out.ready;
      if (in_xfer) begin
        seen.command      = pix_in.command;
        seen.source_value = pix_in.source_value;
        seen.odd_column   = pix_in.odd_column;
        seen.and_bit      = pix_in.and_bit;
        seen.palette_slot = pix_in.palette_slot;
        if (seen.command == CMD_PAL_WRITE) begin
          if (seen.palette_slot < PAL_ENTRIES) pal_shadow[seen.palette_slot] = seen.source_value;
        end else begin
          predicted_argb.push_back(convert_pixel(seen));
        end
      end
      if (out_xfer) begin
        if (predicted_argb.size() == 0) begin
          $error("unexpected result transfer: argb %08h invert %0b",
                 pix_out.argb, pix_out.invert);
          fail_count++;
        end else begin
          want = predicted_argb.pop_front();
          if (pix_out.argb !== want.argb) begin
            $error("argb mismatch: expected %08h, got %08h", want.argb, pix_out.argb);
            fail_count++;
          end
          if (pix_out.invert !== want.invert) begin
            $error("invert mismatch: expected %0b, got %0b", want.invert, pix_out.invert);
            fail_count++;
          end
        end
      end
      if (in_xfer || out_xfer) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    fmt_e        fmt;
    int unsigned r;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = FMT_RGB32;
    pix_in.valid        = 1'b0;
    pix_in.command      = CMD_CONVERT;
    pix_in.source_value = '0;
    pix_in.odd_column   = 1'b0;
    pix_in.and_bit      = 1'b0;
    pix_in.palette_slot = '0;
    pix_out.ready       = 1'b0;
    cur_format          = FMT_RGB32;
    pal_loaded          = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // format left at its reset value: 32-bit color, alpha byte ignored
    push_convert(32'h0000_0000, 1'b0, 1'b1);
    push_convert(32'h12ff_ffff, 1'b1, 1'b1);
    push_convert(32'hff00_0000, 1'b0, 1'b0);
    push_convert(32'h00ff_ffff, 1'b1, 1'b0);
    push_convert(32'h7f12_3456, 1'b0, 1'b1);

    // 5:5:5 white expands short of all ones, upper bits are ignored
    set_format(FMT_RGB555);
    push_convert(32'hffff_8000, 1'b1, 1'b1);
    push_convert(32'h0000_7fff, 1'b0, 1'b1);
    push_convert(32'h0000_7c1f, 1'b1, 1'b0);
    push_pal_write(4'd0, 32'h5a00_0000);
    push_pal_write(4'd15, 32'ha5ff_ffff);
    push_pal_write(4'd5, 32'h00c0_ffee);

    // palette lookups by either nibble, then a rewrite read right behind it
    set_format(FMT_PAL4);
    push_convert(32'hffff_ff0f, 1'b0, 1'b1);
    push_convert(32'h0000_000f, 1'b1, 1'b1);
    push_convert(32'h0000_00f0, 1'b1, 1'b0);
    push_convert(32'h0000_005f, 1'b0, 1'b1);
    push_pal_write(4'd5, 32'h00ff_ffff);
    push_convert(32'h0000_0050, 1'b0, 1'b1);

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: fmt = FMT_PAL4;
        1: fmt = FMT_RGB32;
        2: fmt = FMT_RGB555;
        default: fmt = fmt_e'($urandom_range(0, 2));
      endcase
      set_format(fmt);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          push_pal_write(4'($urandom_range(0, 15)), {8'($urandom()), pick_rgb()});
        end else begin
          push_random_convert(fmt);
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== cursor_pixel_converter.f =====
hdl/cpc_pkg.sv
hdl/cpc_in_if.sv
hdl/cpc_out_if.sv
hdl/cpc_decode.sv
hdl/cpc_mask.sv
hdl/cursor_pixel_converter.sv
tb/sv/cursor_pixel_converter_tb.sv
